>>> src/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types and codes for the sorted table search core: request and
// response beats, opcodes and the sequencer states.
// ----------------------------------------------------------------------------
package sts_pkg;

   localparam int VALUE_W = 32;
   localparam int INDEX_W = 6;
   localparam int COUNT_W = 7;

   // Request opcodes
   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_BINARY = 2'd1;
   localparam logic [1:0] OP_INTERP = 2'd2;

   typedef struct packed {
      logic [1:0]                opcode;
      logic [INDEX_W-1:0]        load_index;
      logic signed [VALUE_W-1:0] element_value;
      logic signed [VALUE_W-1:0] search_key;
   } sts_req_type;

   typedef struct packed {
      logic               found;
      logic [COUNT_W-1:0] position;
      logic [COUNT_W-1:0] probe_count;
   } sts_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RD_HI,
      ST_CALC,
      ST_MUL,
      ST_DIV,
      ST_POS,
      ST_PROBE,
      ST_FINISH
   } sts_state_type;

endpackage

>>> src/sorted_table_search_core.sv
// ----------------------------------------------------------------------------
// sorted_table_search_core
// Ascending table of signed 32-bit values with binary and interpolation
// search, driven by a small sequencer over one table read port and one
// restoring divider that only interpolation search uses.
// ----------------------------------------------------------------------------
// A load beat with an index inside the table writes that entry in the cycle it
// is accepted and the core is ready again at once. A search beat holds
// req_stall high until its response is registered. The single registered read
// port means a binary probe passes through the check and probe states. An
// interpolation probe reads t[lo] and t[hi], multiplies and divides with the
// divider producing one quotient bit per cycle, then probes, or skips the
// multiply and divide when the range ends hold equal values. A hit goes from
// the probe state to finish, an exhausted range returns to the check state
// first, and a key outside the range ends stops in the calc state. A search
// with element_count 0 goes from check to finish. A finished response waits
// in an output register, so the next request is taken while it is stalled; a
// search finishing while that register stalls holds req_stall until it drains.
module sorted_table_search_core
   import sts_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  sts_req_type        req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output sts_rsp_type        rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [COUNT_W-1:0] csr_data
);

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int PW = IW + 2;                  // signed lo / hi bounds
   localparam int AW = (IW > INDEX_W) ? IW : INDEX_W;
   localparam int XW = (PW > COUNT_W) ? PW : COUNT_W;
   localparam int NW = IW + VALUE_W;            // interpolation numerator
   localparam int SW = $clog2(IW + 1);

   // Table storage
   logic signed [VALUE_W-1:0] mem [TABLE_DEPTH];
   logic signed [VALUE_W-1:0] rd_data_ff;
   logic [IW-1:0]             rd_addr;
   logic                      mem_we;
   logic [AW-1:0]             idx_wide;
   logic                      idx_ok;

   // Sequencer and datapath registers
   sts_state_type             state_ff, state_in;
   logic [COUNT_W-1:0]        count_ff;
   logic                      interp_ff, interp_in;
   logic signed [VALUE_W-1:0] key_ff, key_in;
   logic signed [PW-1:0]      lo_ff, lo_in;
   logic signed [PW-1:0]      hi_ff, hi_in;
   logic [IW-1:0]             p_ff, p_in;
   logic signed [VALUE_W-1:0] vlo_ff, vlo_in;
   logic [IW-1:0]             span_ff, span_in;
   logic [VALUE_W-1:0]        kdiff_ff, kdiff_in;
   logic [VALUE_W-1:0]        den_ff, den_in;
   logic [VALUE_W-1:0]        rem_ff, rem_in;
   logic [IW-1:0]             quo_ff, quo_in;
   logic [SW-1:0]             step_ff, step_in;
   logic [COUNT_W-1:0]        probes_ff, probes_in;
   logic                      found_ff, found_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   sts_rsp_type               rsp_data_ff, rsp_data_in;

   // Helper terms
   logic signed [PW-1:0]      live;
   logic signed [PW-1:0]      mid;
   logic signed [PW-1:0]      p_ext;
   logic [NW-1:0]             product;
   logic [VALUE_W+1:0]        trial;
   logic [IW-1:0]             interp_pos;
   logic [XW-1:0]             pos_x;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Load address, ignored past the table depth
   assign idx_wide = AW'(req_data.load_index);
   assign idx_ok   = (int'(req_data.load_index) < TABLE_DEPTH);

   // Searched length is clipped to the depth
   always_comb begin
      if (int'(count_ff) > TABLE_DEPTH) begin
         live = PW'(TABLE_DEPTH);
      end else begin
         live = PW'(count_ff);
      end
   end

   assign mid        = lo_ff + ((hi_ff - lo_ff) >>> 1);
   assign p_ext      = signed'(PW'(p_ff));
   assign product    = NW'(span_ff) * NW'(kdiff_ff);
   assign trial      = {1'b0, rem_ff, quo_ff[IW-1]} - {2'b00, den_ff};
   assign interp_pos = lo_ff[IW-1:0] + quo_ff;
   assign pos_x      = XW'(p_ff) + XW'(1);

   // Table write and registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[idx_wide[IW-1:0]] <= req_data.element_value;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         count_ff <= csr_data;
      end
   end

   // State and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      interp_ff   <= interp_in;
      key_ff      <= key_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      p_ff        <= p_in;
      vlo_ff      <= vlo_in;
      span_ff     <= span_in;
      kdiff_ff    <= kdiff_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
      probes_ff   <= probes_in;
      found_ff    <= found_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      interp_in    = interp_ff;
      key_in       = key_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      p_in         = p_ff;
      vlo_in       = vlo_ff;
      span_in      = span_ff;
      kdiff_in     = kdiff_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      probes_in    = probes_ff;
      found_in     = found_ff;
      rsp_data_in  = rsp_data_ff;
      rd_addr      = p_ff;
      mem_we       = 1'b0;
      req_stall    = (state_ff != ST_IDLE);
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_data.opcode) inside
                  OP_LOAD: begin
                     mem_we = idx_ok;
                  end
                  OP_BINARY, OP_INTERP: begin
                     interp_in = (req_data.opcode == OP_INTERP);
                     key_in    = req_data.search_key;
                     lo_in     = '0;
                     hi_in     = live - PW'(1);
                     probes_in = '0;
                     found_in  = 1'b0;
                     state_in  = ST_CHECK;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Range still live? Binary probes mid, interpolation fetches t[lo]
         ST_CHECK: begin
            if (lo_ff > hi_ff) begin
               state_in = ST_FINISH;
            end else if (interp_ff) begin
               rd_addr  = lo_ff[IW-1:0];
               state_in = ST_RD_HI;
            end else begin
               p_in     = mid[IW-1:0];
               rd_addr  = mid[IW-1:0];
               state_in = ST_PROBE;
            end
         end

         ST_RD_HI: begin
            vlo_in   = rd_data_ff;
            rd_addr  = hi_ff[IW-1:0];
            state_in = ST_CALC;
         end

         // t[hi] is on the read port; key outside the ends stops the search
         ST_CALC: begin
            if (key_ff < vlo_ff || key_ff > rd_data_ff) begin
               state_in = ST_FINISH;
            end else if (lo_ff == hi_ff || vlo_ff == rd_data_ff) begin
               p_in     = lo_ff[IW-1:0];
               rd_addr  = lo_ff[IW-1:0];
               state_in = ST_PROBE;
            end else begin
               span_in  = IW'(hi_ff - lo_ff);
               kdiff_in = VALUE_W'(key_ff - vlo_ff);
               den_in   = VALUE_W'(rd_data_ff - vlo_ff);
               state_in = ST_MUL;
            end
         end

         // Quotient is below 2**IW, so the upper numerator bits are a
         // valid starting remainder
         ST_MUL: begin
            rem_in   = product[NW-1:IW];
            quo_in   = product[IW-1:0];
            step_in  = SW'(IW);
            state_in = ST_DIV;
         end

         // One restoring divide step per cycle
         ST_DIV: begin
            if (trial[VALUE_W+1]) begin
               rem_in = {rem_ff[VALUE_W-2:0], quo_ff[IW-1]};
            end else begin
               rem_in = trial[VALUE_W-1:0];
            end
            quo_in    = quo_ff << 1;
            quo_in[0] = ~trial[VALUE_W+1];
            step_in   = step_ff - SW'(1);
            if (step_ff == SW'(1)) begin
               state_in = ST_POS;
            end
         end

         ST_POS: begin
            p_in     = interp_pos;
            rd_addr  = interp_pos;
            state_in = ST_PROBE;
         end

         // Compare the probed entry and narrow the range
         ST_PROBE: begin
            probes_in = probes_ff + COUNT_W'(1);
            if (rd_data_ff == key_ff) begin
               found_in = 1'b1;
               state_in = ST_FINISH;
            end else begin
               if (rd_data_ff < key_ff) begin
                  lo_in = p_ext + PW'(1);
               end else begin
                  hi_in = p_ext - PW'(1);
               end
               state_in = ST_CHECK;
            end
         end

         // Hand the beat to the output register once it is free
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.found        = found_ff;
               rsp_data_in.position     = found_ff ? pos_x[COUNT_W-1:0] : '0;
               rsp_data_in.probe_count  = probes_ff;
               state_in                 = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> src/sts_checker.sv
// ----------------------------------------------------------------------------
// sts_checker
// Port-level checks for the sorted table search core, bound to the top level.
// ----------------------------------------------------------------------------
module sts_checker
   import sts_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input sts_req_type        req_data,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input sts_rsp_type        rsp_data,
   input logic               csr_valid,
   input logic               csr_ready,
   input logic [COUNT_W-1:0] csr_data
);

   // A stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response beat changed while stalled");

   // A miss reports no position
   a_miss_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.position == '0)
      else $error("miss with nonzero position");

   // A hit needs at least one probe
   a_hit_probe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.found |-> rsp_data.probe_count != '0)
      else $error("hit with zero probes");

   // A search beat makes the core busy in the next cycle
   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall &&
      (req_data.opcode == OP_BINARY || req_data.opcode == OP_INTERP)
      |=> req_stall)
      else $error("core not busy after a search beat");

   // A load beat leaves the core ready
   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.opcode == OP_LOAD |=> !req_stall)
      else $error("core busy after a load beat");

endmodule

bind sorted_table_search_core sts_checker u_sts_checker (.*);

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sorted_table_search_core. It loads ascending,
// skewed, duplicate-heavy, flat and unsorted tables and sweeps element_count
// from empty to beyond the table depth. Binary and interpolation searches are
// predicted by a scoreboard and every response beat is compared field by field.
// The request channel idles and the response channel stalls at random.
// ----------------------------------------------------------------------------
module tb;
   import sts_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH    = 64;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 50;
   localparam int SETTLE_CYCLES  = 10;
   localparam int TAIL_CYCLES    = 50;
   localparam int LONG_HOLD      = 300;
   localparam int CYCLE_LIMIT    = 4000000;
   localparam int REPORT_LIMIT   = 10;
   localparam int VALUE_MIN      = -2147483648;
   localparam int VALUE_MAX      = 2147483647;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef enum int {
      SHAPE_EVEN,
      SHAPE_SKEW,
      SHAPE_DUP,
      SHAPE_FULL,
      SHAPE_FLAT,
      SHAPE_UNSORTED
   } table_shape_type;

   // -------------------------------------------------------------------------
   // Scoreboard: shadow table, element count and queue of predicted responses
   // -------------------------------------------------------------------------
   class search_scoreboard;
      int          entries[TABLE_DEPTH];
      int          element_count;
      sts_rsp_type expected_q[$];
      int          mismatches;

      function new();
         element_count = 0;
         mismatches    = 0;
         foreach (entries[i]) entries[i] = 0;
      endfunction

      function void set_count(int value);
         element_count = value;
      endfunction

      function int live_count();
         return (element_count > TABLE_DEPTH) ? TABLE_DEPTH : element_count;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // halve the live range each probe
      function sts_rsp_type search_binary(int key);
         sts_rsp_type r;
         int          lo;
         int          hi;
         int          mid;
         int          probes;
         bit          done;
         r = '0;
         lo = 0;
         hi = live_count() - 1;
         probes = 0;
         done = 1'b0;
         while (!done && lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            probes++;
            if (entries[mid] == key) begin
               r.found    = 1'b1;
               r.position = COUNT_W'(mid + 1);
               done       = 1'b1;
            end else if (entries[mid] < key) begin
               lo = mid + 1;
            end else begin
               hi = mid - 1;
            end
         end
         r.probe_count = COUNT_W'(probes);
         return r;
      endfunction

      // place each probe by exact integer interpolation between range ends
      function sts_rsp_type search_interp(int key);
         sts_rsp_type r;
         int          lo;
         int          hi;
         int          p;
         int          probes;
         longint      vlo;
         longint      vhi;
         longint      num;
         longint      den;
         bit          done;
         r = '0;
         lo = 0;
         hi = live_count() - 1;
         probes = 0;
         done = 1'b0;
         while (!done && lo <= hi) begin
            vlo = entries[lo];
            vhi = entries[hi];
            if (longint'(key) < vlo || longint'(key) > vhi) begin
               // key outside the range ends: miss, not a probe
               done = 1'b1;
            end else begin
               if (lo == hi || vlo == vhi) begin
                  p = lo;
               end else begin
                  num = longint'(hi - lo) * (longint'(key) - vlo);
                  den = vhi - vlo;
                  p   = lo + int'(num / den);
               end
               probes++;
               if (entries[p] == key) begin
                  r.found    = 1'b1;
                  r.position = COUNT_W'(p + 1);
                  done       = 1'b1;
               end else if (entries[p] < key) begin
                  lo = p + 1;
               end else begin
                  hi = p - 1;
               end
            end
         end
         r.probe_count = COUNT_W'(probes);
         return r;
      endfunction

      // accepted request beat: update the table or queue a prediction
      function void note_request(sts_req_type item);
         case (item.opcode)
            OP_LOAD: begin
               if (int'(item.load_index) < TABLE_DEPTH)
                  entries[item.load_index] = item.element_value;
            end
            OP_BINARY: expected_q.push_back(search_binary(item.search_key));
            OP_INTERP: expected_q.push_back(search_interp(item.search_key));
            default: ;
         endcase
      endfunction

      // accepted response beat: compare against the oldest prediction
      function void check_response(sts_rsp_type got);
         sts_rsp_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("[%0t] unexpected response: found %0d position %0d probes %0d",
                        $realtime, got.found, got.position, got.probe_count);
            return;
         end
         want = expected_q.pop_front();
         if (got.found !== want.found || got.position !== want.position ||
             got.probe_count !== want.probe_count) begin
            mismatches++;
            // fields are found/position/probes
            if (mismatches <= REPORT_LIMIT)
               $display("[%0t] mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
                        $realtime, want.found, want.position, want.probe_count,
                        got.found, got.position, got.probe_count);
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   sts_req_type        req_data;
   logic               rsp_valid;
   logic               rsp_stall;
   sts_rsp_type        rsp_data;
   logic               csr_valid;
   logic               csr_ready;
   logic [COUNT_W-1:0] csr_data;

   search_scoreboard   sb;
   int                 table_plan[TABLE_DEPTH];
   int                 hold_request;
   int                 hold_left;
   int                 run_left;
   bit                 stall_on;
   bit                 burst_mode;
   int                 cycle_count;

   sorted_table_search_core #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // cycle limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

   // beat monitor: check responses before noting requests of the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_data);
         if (req_valid && !req_stall) sb.note_request(req_data);
      end
   end

   // receiver: random stall runs, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         run_left = 0;
         hold_left = 0;
      end else begin
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (run_left == 0) begin
               case ($urandom_range(0, 99)) inside
                  [0:49]:  begin stall_on = 1'b0; run_left = $urandom_range(1, 16); end
                  [50:84]: begin stall_on = 1'b1; run_left = $urandom_range(1, 3); end
                  [85:95]: begin stall_on = 1'b1; run_left = $urandom_range(4, 12); end
                  default: begin stall_on = 1'b1; run_left = $urandom_range(30, 80); end
               endcase
            end
            run_left--;
            rsp_stall <= stall_on;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   function automatic int pick_gap();
      if (burst_mode) return 0;
      case ($urandom_range(0, 99)) inside
         [0:49]:  return 0;
         [50:84]: return $urandom_range(1, 3);
         [85:95]: return $urandom_range(4, 12);
         default: return $urandom_range(30, 80);
      endcase
   endfunction

   // offer one request beat and hold it until accepted
   task automatic send_req(input sts_req_type item);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_search(input logic [1:0] op, input int key);
      sts_req_type item;
      item.opcode        = op;
      item.load_index    = INDEX_W'($urandom);
      item.element_value = VALUE_W'($urandom);
      item.search_key    = key;
      send_req(item);
   endtask

   task automatic send_load(input int index, input int value);
      sts_req_type item;
      item.opcode        = OP_LOAD;
      item.load_index    = INDEX_W'(index);
      item.element_value = value;
      item.search_key    = VALUE_W'($urandom);
      send_req(item);
   endtask

   task automatic send_unused();
      sts_req_type item;
      item.opcode        = OP_UNUSED;
      item.load_index    = INDEX_W'($urandom);
      item.element_value = VALUE_W'($urandom);
      item.search_key    = VALUE_W'($urandom);
      send_req(item);
   endtask

   // wait until every predicted response has been taken and the core is idle
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_count(input int value);
      csr_valid <= 1'b1;
      csr_data  <= COUNT_W'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sb.set_count(value);
   endtask

   // build a table image of the given shape
   task automatic plan_table(input table_shape_type shape);
      longint acc;
      longint step;
      case (shape)
         SHAPE_SKEW: acc = -longint'($urandom_range(0, 1000));
         SHAPE_DUP:  acc = longint'($urandom_range(0, 2000)) - 1000;
         default:    acc = -longint'($urandom_range(0, 1 << 24));
      endcase
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         case (shape)
            SHAPE_EVEN: step = $urandom_range(1, 1 << 16);
            SHAPE_SKEW: step = (i < 52) ? longint'($urandom_range(0, 3))
                                        : longint'(1) << $urandom_range(16, 28);
            SHAPE_DUP:  step = $urandom_range(0, 1);
            default:    step = 0;
         endcase
         if (i > 0) acc = acc + step;
         if (acc > VALUE_MAX) acc = VALUE_MAX;
         case (shape)
            SHAPE_FULL: begin
               // spans the whole signed range, ends at the extremes
               if (i == 0) table_plan[i] = VALUE_MIN;
               else if (i == TABLE_DEPTH - 1) table_plan[i] = VALUE_MAX;
               else table_plan[i] = int'(longint'(VALUE_MIN) + longint'(i) * 68174084 +
                                         longint'($urandom_range(0, 1000)));
            end
            SHAPE_FLAT:     table_plan[i] = (i == 0) ? int'($urandom) : table_plan[0];
            SHAPE_UNSORTED: table_plan[i] = int'($urandom);
            default:        table_plan[i] = int'(acc);
         endcase
      end
   endtask

   // load the first n entries of the plan, ascending or descending
   task automatic fill_table(input int n);
      bit down;
      int index;
      down = $urandom_range(0, 1);
      for (int i = 0; i < n; i++) begin
         index = down ? n - 1 - i : i;
         send_load(index, table_plan[index]);
      end
   endtask

   function automatic int pick_key();
      int idx;
      int live;
      live = sb.live_count();
      idx  = (live > 0) ? $urandom_range(0, live - 1) : 0;
      case ($urandom_range(0, 99)) inside
         [0:54]:  return sb.entries[idx];
         [55:69]: return $urandom_range(0, 1) ? sb.entries[idx] + 1 : sb.entries[idx] - 1;
         [70:87]: return int'($urandom);
         default: begin
            case ($urandom_range(0, 3))
               0:       return VALUE_MIN;
               1:       return VALUE_MAX;
               2:       return 0;
               default: return -1;
            endcase
         end
      endcase
   endfunction

   // reload an entry, mostly with a value that keeps the order
   task automatic send_random_load();
      int              index;
      longint          a;
      longint          b;
      longint unsigned span;
      int              value;
      index = $urandom_range(0, TABLE_DEPTH - 1);
      a = (index > 0) ? sb.entries[index - 1] : sb.entries[index];
      b = (index < TABLE_DEPTH - 1) ? sb.entries[index + 1] : sb.entries[index];
      if (a > b || $urandom_range(0, 99) < 20) begin
         value = int'($urandom);
      end else begin
         span  = unsigned'(b - a) + 64'd1;
         value = int'(a + longint'({$urandom, $urandom} % span));
      end
      send_load(index, value);
   endtask

   task automatic send_random_item();
      case ($urandom_range(0, 99)) inside
         [0:69]:  send_search($urandom_range(0, 1) ? OP_BINARY : OP_INTERP, pick_key());
         [70:91]: send_random_load();
         default: send_unused();
      endcase
   endtask

   function automatic int pick_count();
      case ($urandom_range(0, 99)) inside
         [0:44]:  return TABLE_DEPTH;
         [45:54]: return $urandom_range(TABLE_DEPTH + 1, 127);
         [55:64]: return $urandom_range(0, 2);
         default: return $urandom_range(3, TABLE_DEPTH - 1);
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int count;
      int n_load;
      sb           = new();
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_valid    = 1'b0;
      csr_data     = '0;
      hold_request = 0;
      burst_mode   = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: full-range table, extreme keys, hits and misses
      plan_table(SHAPE_FULL);
      write_count(TABLE_DEPTH);
      fill_table(TABLE_DEPTH);
      send_search(OP_BINARY, VALUE_MIN);
      send_search(OP_INTERP, VALUE_MIN);
      send_search(OP_BINARY, VALUE_MAX);
      send_search(OP_INTERP, VALUE_MAX);
      send_search(OP_BINARY, table_plan[20]);
      send_search(OP_INTERP, table_plan[20]);
      send_search(OP_BINARY, table_plan[40] + 1);
      send_search(OP_INTERP, table_plan[40] + 1);
      send_search(OP_INTERP, 0);
      send_search(OP_BINARY, -1);
      send_unused();

      // empty table
      settle();
      write_count(0);
      send_search(OP_BINARY, 7);
      send_search(OP_INTERP, 7);

      // one entry, then two
      settle();
      write_count(1);
      send_search(OP_INTERP, table_plan[0]);
      send_search(OP_BINARY, 5);
      settle();
      write_count(2);
      send_search(OP_INTERP, table_plan[1]);
      send_search(OP_BINARY, table_plan[1]);

      // count beyond the depth acts as the depth
      settle();
      write_count(127);
      send_search(OP_BINARY, table_plan[TABLE_DEPTH - 1]);
      send_search(OP_INTERP, table_plan[50]);

      // random phases over table shapes and counts
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         settle();
         count = pick_count();
         write_count(count);
         burst_mode = ($urandom_range(0, 3) == 0);
         plan_table(table_shape_type'(ph % 6));
         n_load = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
         fill_table(n_load);
         if (ph == 1) begin
            // back up the core behind a long receiver hold-off
            burst_mode = 1'b1;
            hold_request = LONG_HOLD;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) send_random_item();
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> files.f
src/sts_pkg.sv
src/sorted_table_search_core.sv
src/sts_checker.sv
dv/tb.sv
